>>> rtl/core/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared field widths, operation and status codes, and the command bundle
// passed from the controller to the datapath of the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ID_W     = 6;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 7;

  // operation codes; the fourth code is a no-op
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd4;

  typedef struct packed {
    logic load;    // capture item and run the parallel compare
    logic update;  // shift the cells and load the result register
  } prq_cmd_t;

endpackage

>>> rtl/core/prq_ctrl.sv
// ----------------------------------------------------------------------------
// prq_ctrl
// Two-state controller: takes an item, then commits the queue update once
// the result register is free or being emptied.
// ----------------------------------------------------------------------------
module prq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output prq_pkg::prq_cmd_t cmd_o
);
  import prq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.update = (state_q == ST_UPD) && (!out_valid_q || !out_stall_i);
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (cmd_o.update) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_UPD))
    else $error("accepted item did not move to update");

  a_rise_after_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_UPD))
    else $error("result appeared without an update");

  a_update_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> (out_valid_o && state_q == ST_IDLE))
    else $error("update did not present a result");

endmodule

>>> rtl/core/prq_datapath.sv
// ----------------------------------------------------------------------------
// prq_datapath
// Sorted shift-register cells with per-cell id and priority comparators,
// entry count and the result register.
// ----------------------------------------------------------------------------
module prq_datapath #(
  parameter int unsigned QUEUE_DEPTH   = 64,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  prq_pkg::prq_cmd_t                   cmd_i,
  input  logic [prq_pkg::FUNC_W-1:0]          func_i,
  input  logic [prq_pkg::ID_W-1:0]            task_id_i,
  input  logic signed [prq_pkg::PRIO_W-1:0]   task_priority_i,
  output logic [prq_pkg::ID_W-1:0]            out_id_o,
  output logic signed [prq_pkg::PRIO_W-1:0]   out_priority_o,
  output logic [prq_pkg::STATUS_W-1:0]        status_o,
  output logic [prq_pkg::OCC_W-1:0]           occupancy_o
);
  import prq_pkg::*;

  localparam int unsigned D     = QUEUE_DEPTH;
  localparam int unsigned PB    = PRIORITY_BITS;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic signed [32:0] PRIO_MAX = (33'sd1 <<< (PRIORITY_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] PRIO_MIN = -PRIO_MAX - 33'sd1;

  // cells, head at index 0
  logic [ID_W-1:0]        id_q [D];
  logic [ID_W-1:0]        id_d [D];
  logic signed [PB-1:0]   pr_q [D];
  logic signed [PB-1:0]   pr_d [D];
  logic [CNT_W-1:0]       count_q, count_d;

  // captured item and compare results
  logic [FUNC_W-1:0]      func_q;
  logic [ID_W-1:0]        tid_q;
  logic signed [PB-1:0]   tpr_q, tpr_d;
  logic [D-1:0]           match_q, match_d;
  logic [D-1:0]           ge_q, ge_d;

  logic [ID_W-1:0]        out_id_q, out_id_d;
  logic signed [PRIO_W-1:0] out_pr_q, out_pr_d;
  logic [STATUS_W-1:0]    status_q, status_d;

  logic                   dup, full, empty, found;
  logic                   do_insert, do_take;
  logic [D-1:0]           hit, after, prev_ge;
  logic [ID_W-1:0]        sel_id;
  logic signed [PB-1:0]   sel_pr;
  logic signed [32:0]     wide_pr;

  function automatic logic [D-1:0] prefix_or(input logic [D-1:0] v);
    logic [D-1:0] r;
    r = v;
    for (int s = 1; s < int'(D); s = s * 2) begin
      r = r | (r << s);
    end
    return r;
  endfunction

  // saturate incoming priority to the stored width
  always_comb begin
    wide_pr = 33'(task_priority_i);
    if (wide_pr > PRIO_MAX) begin
      wide_pr = PRIO_MAX;
    end else if (wide_pr < PRIO_MIN) begin
      wide_pr = PRIO_MIN;
    end
    tpr_d = PB'(wide_pr);
  end

  // parallel compare against every live cell
  always_comb begin
    for (int i = 0; i < int'(D); i++) begin
      match_d[i] = (CNT_W'(i) < count_q) && (id_q[i] == task_id_i);
      ge_d[i]    = (CNT_W'(i) < count_q) && (pr_q[i] >= tpr_d);
    end
  end

  always_comb begin
    dup     = |match_q;
    full    = (count_q == CNT_W'(D));
    empty   = (count_q == '0);
    hit     = (func_q == FUNC_POP) ? D'(1) : match_q;
    found   = |hit;
    after   = prefix_or(hit);
    prev_ge = {ge_q[D-2:0], 1'b1};
    sel_id  = '0;
    sel_pr  = '0;
    for (int i = 0; i < int'(D); i++) begin
      sel_id = sel_id | ({ID_W{hit[i]}} & id_q[i]);
      sel_pr = sel_pr | ({PB{hit[i]}} & pr_q[i]);
    end
  end

  always_comb begin
    do_insert = 1'b0;
    do_take   = 1'b0;
    status_d  = STATUS_OK;
    out_id_d  = '0;
    out_pr_d  = '0;
    count_d   = count_q;
    case (func_q)
      FUNC_INSERT: begin
        if (dup) begin
          status_d = STATUS_DUPLICATE;
        end else if (full) begin
          status_d = STATUS_FULL;
        end else begin
          do_insert = 1'b1;
          count_d   = count_q + CNT_W'(1);
        end
      end
      FUNC_POP, FUNC_REMOVE: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else if (!found) begin
          status_d = STATUS_NOT_FOUND;
        end else begin
          do_take  = 1'b1;
          count_d  = count_q - CNT_W'(1);
          out_id_d = sel_id;
          out_pr_d = PRIO_W'(33'(sel_pr));
        end
      end
      default: begin
        status_d = STATUS_OK;
      end
    endcase
  end

  // next cell contents: shift down on insert, shift up on removal
  always_comb begin
    for (int i = 0; i < int'(D); i++) begin
      id_d[i] = id_q[i];
      pr_d[i] = pr_q[i];
    end
    if (do_insert) begin
      if (!ge_q[0]) begin
        id_d[0] = tid_q;
        pr_d[0] = tpr_q;
      end
      for (int i = 1; i < int'(D); i++) begin
        if (!ge_q[i]) begin
          id_d[i] = prev_ge[i] ? tid_q : id_q[i-1];
          pr_d[i] = prev_ge[i] ? tpr_q : pr_q[i-1];
        end
      end
    end else if (do_take) begin
      for (int i = 0; i < int'(D) - 1; i++) begin
        if (after[i]) begin
          id_d[i] = id_q[i+1];
          pr_d[i] = pr_q[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.update) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      tid_q   <= task_id_i;
      tpr_q   <= tpr_d;
      match_q <= match_d;
      ge_q    <= ge_d;
    end
    if (cmd_i.update) begin
      for (int i = 0; i < int'(D); i++) begin
        id_q[i] <= id_d[i];
        pr_q[i] <= pr_d[i];
      end
      out_id_q <= out_id_d;
      out_pr_q <= out_pr_d;
      status_q <= status_d;
    end
  end

  assign out_id_o       = out_id_q;
  assign out_priority_o = out_pr_q;
  assign status_o       = status_q;
  assign occupancy_o    = OCC_W'(count_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(D))
    else $error("entry count beyond queue depth");

  a_unique_ids : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> $onehot0(match_q))
    else $error("id held by more than one cell");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> (count_q == $past(count_q) + CNT_W'(1)
                      || count_q == $past(count_q) - CNT_W'(1)
                      || count_q == $past(count_q)))
    else $error("entry count moved by more than one");

endmodule

>>> rtl/core/priority_ready_queue_top.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_top
// Ready queue of task ids sorted by descending priority, fifo among equal
// priorities, with insert, pop-head and remove-by-id operations.
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   in      | in_valid_i, in_stall_o, func_i, task_id_i,      | in
//           | task_priority_i                                 |
//   out     | out_valid_o, out_stall_i, out_id_o,             | out
//           | out_priority_o, status_o, occupancy_o           |
//
// every item passes through the parallel compare across all cells, then the
// shift of the sorted cells and the load of the result register
// one result per item; a new item is taken while the last result waits
// the update cycle holds while a full result register is stalled
// reset clears the entry count, the controller state and the result valid flag; the cells need no clearing
// ----------------------------------------------------------------------------
module priority_ready_queue_top #(
  parameter int unsigned QUEUE_DEPTH   = 64,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [prq_pkg::FUNC_W-1:0]          func_i,
  input  logic [prq_pkg::ID_W-1:0]            task_id_i,
  input  logic signed [prq_pkg::PRIO_W-1:0]   task_priority_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [prq_pkg::ID_W-1:0]            out_id_o,
  output logic signed [prq_pkg::PRIO_W-1:0]   out_priority_o,
  output logic [prq_pkg::STATUS_W-1:0]        status_o,
  output logic [prq_pkg::OCC_W-1:0]           occupancy_o
);
  import prq_pkg::*;

  prq_cmd_t cmd;

  prq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  prq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (func_i),
    .task_id_i       (task_id_i),
    .task_priority_i (task_priority_i),
    .out_id_o        (out_id_o),
    .out_priority_o  (out_priority_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

endmodule
